[hdl/superfast_byte_hash_assert.svh]
// Assertion macros shared by the superfast_byte_hash RTL.
// Needs nothing else; included inside module bodies after the logic.
`ifndef SUPERFAST_BYTE_HASH_ASSERT_SVH
`define SUPERFAST_BYTE_HASH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfh assertion failed");

// Next-cycle implication, disabled during reset.
`define SFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfh assertion failed");

`endif

[hdl/sfh_pkg.sv]
// Types, constants and round functions for the superfast_byte_hash block.
// Used by sfh_front, sfh_fifo, sfh_back and the top level.
`default_nettype none

package sfh_pkg;

    localparam logic [31:0] SEED = 32'h9e3779b9;

    // Work to be done on one queued word
    typedef enum logic [2:0] {
        OP_FULL  = 3'd0,
        OP_TAIL3 = 3'd1,
        OP_TAIL2 = 3'd2,
        OP_TAIL1 = 3'd3,
        OP_NONE  = 3'd4,
        OP_EMPTY = 3'd5
    } t_op;

    typedef struct packed {
        logic [31:0] data;
        t_op         op;
        logic        fin;
    } t_cmd;

    // Two-halfword mixing round
    function automatic logic [31:0] full_round(input logic [31:0] h_in,
                                               input logic [31:0] w);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, w[15:0]};
        t = ({5'd0, w[31:16], 11'd0}) ^ h;
        h = {h[15:0], 16'd0} ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Three trailing bytes
    function automatic logic [31:0] tail3(input logic [31:0] h_in,
                                          input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'd0, w[15:0]};
        h = h ^ {h[15:0], 16'd0};
        h = h ^ {{6{w[23]}}, w[23:16], 18'd0};
        h = h + (h >> 11);
        return h;
    endfunction

    // Two trailing bytes
    function automatic logic [31:0] tail2(input logic [31:0] h_in,
                                          input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
        return h;
    endfunction

    // One trailing byte, sign-extended
    function automatic logic [31:0] tail1(input logic [31:0] h_in,
                                          input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {{24{w[7]}}, w[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
        return h;
    endfunction

    // First half of the avalanche
    function automatic logic [31:0] aval_lo(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // Second half of the avalanche
    function automatic logic [31:0] aval_hi(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

`default_nettype wire

[hdl/sfh_front.sv]
// Front end: accepts message words, tracks whether bytes were seen, and
// classifies each word into a queue command. Depends on sfh_pkg.
`default_nettype none

module sfh_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_data_word,
    input  wire logic [2:0]    i_byte_count,
    input  wire logic          i_last,
    input  wire logic          i_full,
    output sfh_pkg::t_cmd      o_cmd,
    output logic               o_push
);
    import sfh_pkg::*;

    logic r_seen;
    logic n_seen;
    t_op  op;

    assign o_push = i_valid & ~i_full;

    // Classify the word by its count, saturating counts above four
    always_comb begin
        if (!i_last) begin
            op = OP_FULL;
        end else if (i_byte_count >= 3'd4) begin
            op = OP_FULL;
        end else if (i_byte_count == 3'd3) begin
            op = OP_TAIL3;
        end else if (i_byte_count == 3'd2) begin
            op = OP_TAIL2;
        end else if (i_byte_count == 3'd1) begin
            op = OP_TAIL1;
        end else if (r_seen) begin
            op = OP_NONE;
        end else begin
            op = OP_EMPTY;
        end
    end

    assign o_cmd = '{data: i_data_word, op: op, fin: i_last};

    // Set on a middle word, drop at message end
    always_comb begin
        n_seen = r_seen;
        if (o_push) begin
            n_seen = ~i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

[hdl/sfh_fifo.sv]
// Short command queue between front and back ends.
// Depends on sfh_pkg for the command type.
`default_nettype none

module sfh_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfh_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output sfh_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import sfh_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers with wrap at depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `include "superfast_byte_hash_assert.svh"

    `SFH_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `SFH_ASSERT_NEXT(a_push_only, i_clk, i_rst_n, do_push && !do_pop, r_count != '0)

endmodule

`default_nettype wire

[hdl/sfh_back.sv]
// Back end: runs the hash rounds on queued words and the avalanche on
// finished messages, three register stages to the output. Uses sfh_pkg.
`default_nettype none

module sfh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfh_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_hash_value
);
    import sfh_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] r_a;
    logic        r_a_zero;
    logic        r_a_vld;
    logic [31:0] r_b;
    logic        r_b_zero;
    logic        r_b_vld;
    logic [31:0] r_out;
    logic        r_out_vld;
    logic [31:0] h_rnd;
    logic        out_ready;
    logic        b_ready;
    logic        a_ready;

    // Ready chain from the output back to the queue
    assign out_ready = ~r_out_vld | ~i_stall;
    assign b_ready   = ~r_b_vld | out_ready;
    assign a_ready   = ~r_a_vld | b_ready;
    assign o_pop     = ~i_empty & (~i_cmd.fin | a_ready);

    // Apply the round for this word
    always_comb begin
        unique case (i_cmd.op)
            OP_FULL:  h_rnd = full_round(r_hash, i_cmd.data);
            OP_TAIL3: h_rnd = tail3(r_hash, i_cmd.data);
            OP_TAIL2: h_rnd = tail2(r_hash, i_cmd.data);
            OP_TAIL1: h_rnd = tail1(r_hash, i_cmd.data);
            OP_NONE:  h_rnd = r_hash;
            OP_EMPTY: h_rnd = r_hash;
            default:  h_rnd = r_hash;
        endcase
    end

    // Running hash, reload seed at message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= SEED;
        end else if (o_pop) begin
            r_hash <= i_cmd.fin ? SEED : h_rnd;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= o_pop & i_cmd.fin;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_b_vld;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a      <= h_rnd;
            r_a_zero <= (i_cmd.op == OP_EMPTY);
        end
        if (b_ready) begin
            r_b      <= aval_lo(r_a);
            r_b_zero <= r_a_zero;
        end
        if (out_ready) begin
            r_out <= r_b_zero ? 32'd0 : aval_hi(r_b);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hash_value = r_out;

    `include "superfast_byte_hash_assert.svh"

    `SFH_ASSERT_NEXT(a_seed_reload, i_clk, i_rst_n, o_pop && i_cmd.fin, r_hash == SEED)
    `SFH_ASSERT_NEXT(a_empty_flag, i_clk, i_rst_n, o_pop && i_cmd.op == OP_EMPTY,
                     r_a_vld && r_a_zero)
    `SFH_ASSERT_NEXT(a_hold_a, i_clk, i_rst_n, r_a_vld && !b_ready, r_a_vld)

endmodule

`default_nettype wire

[hdl/superfast_byte_hash.sv]
// SuperFastHash (seed 0x9e3779b9) of a byte message given as 32-bit little-endian
// words. One word is taken per clock while o_stall is low; the running hash takes
// one round per cycle while words are queued, which sets the rate. A word is
// written into a short queue when it is accepted, and its round is registered into
// the running hash when it is popped; a message's hash then passes the round
// register r_a and two avalanche stages to the output. The queue of FIFO_DEPTH words
// lets the input keep flowing while a result waits on output stall. Top level;
// uses sfh_pkg.
`default_nettype none

module superfast_byte_hash #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [31:0]   i_data_word,
    input  wire logic [2:0]    i_byte_count,
    input  wire logic          i_last,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_hash_value
);
    import sfh_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_stall = full;

    sfh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_full       (full),
        .o_cmd        (front_cmd),
        .o_push       (push)
    );

    sfh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    sfh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (queue_cmd),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire
